// ===== rtl/psgfrd_pkg.sv =====
// Shared types, codes and the bit remap function of the frame register dispatcher.
// No dependencies.
`timescale 1ns / 1ps
package psgfrd_pkg;

  localparam int SLOTS       = 32;
  localparam int PTR_W       = 5;
  localparam int ROUND_W     = 5;
  localparam int SHADOW_W    = 4;
  localparam int MAX_CHIPS   = 4;

  localparam logic [7:0] END_MARK  = 8'hFF;
  localparam logic [7:0] IDLE_REG  = 8'd17;
  localparam logic [7:0] SHADOW_N  = 8'd16;
  localparam logic [3:0] MIXER_REG = 4'd7;
  localparam logic [7:0] MIXER_OFF = 8'h3F;
  localparam logic [23:0] MAP_RESET = 24'hFAC688;
  localparam logic [7:0] FPS_RESET = 8'd50;

  localparam logic [2:0] OP_ENQUEUE = 3'd0;
  localparam logic [2:0] OP_TICK    = 3'd1;
  localparam logic [2:0] OP_RESEND  = 3'd2;
  localparam logic [2:0] OP_CLEAR   = 3'd3;
  localparam logic [2:0] OP_FLUSH   = 3'd4;

  localparam logic [1:0] KIND_ADDR = 2'd0;
  localparam logic [1:0] KIND_DATA = 2'd1;
  localparam logic [1:0] KIND_ACK  = 2'd2;
  localparam logic [1:0] KIND_REJ  = 2'd3;

  localparam logic [2:0] CFG_MAP0     = 3'd0;
  localparam logic [2:0] CFG_FPS      = 3'd4;
  localparam logic [2:0] CFG_PULSE_EN = 3'd5;

  typedef struct packed {
    logic [2:0] opcode;
    logic [1:0] chip_select;
    logic [7:0] reg_number;
    logic [7:0] reg_value;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] bus_bytes;
    logic        second_pulse;
    logic        last;
  } out_item_t;

  typedef enum logic [2:0] {
    SEL_ACK        = 3'd0,
    SEL_REJ        = 3'd1,
    SEL_FRAME_ADDR = 3'd2,
    SEL_FRAME_DATA = 3'd3,
    SEL_REP_ADDR   = 3'd4,
    SEL_REP_DATA   = 3'd5
  } out_sel_t;

  typedef struct packed {
    logic     push;
    logic     flush;
    logic     clear_shadow;
    logic     start_frame;
    logic     pop;
    logic     round_inc;
    logic     frame_done;
    logic     rep_start;
    logic     rep_step;
    logic     load;
    out_sel_t sel;
    logic     last;
  } cmd_t;

  typedef struct packed {
    logic enq_ok;
    logic any_nonempty;
    logic frame_end;
    logic rep_last;
    logic out_free;
  } status_t;

  // Route each source bit to the destination position its 3-bit field names.
  function automatic logic [7:0] remap(input logic [23:0] map, input logic [7:0] b);
    logic [7:0] r;
    r = '0;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) r[map[3*i +: 3]] = 1'b1;
    end
    return r;
  endfunction

endpackage

// ===== rtl/psgfrd_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module psgfrd_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/psgfrd_ctrl.sv =====
// Controller state machine: sequences enqueue replies, frame rounds and replays.
// Depends on psgfrd_pkg.
`timescale 1ns / 1ps
module psgfrd_ctrl
  import psgfrd_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  logic [2:0] opcode,
  input  status_t  sts,
  output cmd_t     cmd
);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_ENQ    = 6'b000010,
    S_F_ADDR = 6'b000100,
    S_F_DATA = 6'b001000,
    S_R_ADDR = 6'b010000,
    S_R_DATA = 6'b100000
  } state_t;

  state_t state, state_next;
  logic   rej, rej_next;
  logic   accept;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;

  always_comb begin
    state_next = state;
    rej_next   = rej;
    cmd        = '0;
    cmd.sel    = SEL_ACK;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          unique case (opcode)
            OP_ENQUEUE: begin
              cmd.push   = sts.enq_ok;
              rej_next   = !sts.enq_ok;
              state_next = S_ENQ;
            end
            OP_TICK: begin
              if (sts.any_nonempty) begin
                cmd.start_frame = 1'b1;
                state_next      = S_F_ADDR;
              end
            end
            OP_RESEND: begin
              cmd.rep_start = 1'b1;
              state_next    = S_R_ADDR;
            end
            OP_CLEAR: begin
              cmd.clear_shadow = 1'b1;
              cmd.rep_start    = 1'b1;
              state_next       = S_R_ADDR;
            end
            OP_FLUSH: cmd.flush = 1'b1;
            default: ;
          endcase
        end
      end
      S_ENQ: begin
        if (sts.out_free) begin
          cmd.load   = 1'b1;
          cmd.sel    = rej ? SEL_REJ : SEL_ACK;
          cmd.last   = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_F_ADDR: begin
        if (sts.out_free) begin
          cmd.pop    = 1'b1;
          cmd.load   = 1'b1;
          cmd.sel    = SEL_FRAME_ADDR;
          state_next = S_F_DATA;
        end
      end
      S_F_DATA: begin
        if (sts.out_free) begin
          cmd.load = 1'b1;
          cmd.sel  = SEL_FRAME_DATA;
          if (sts.frame_end) begin
            cmd.last       = 1'b1;
            cmd.frame_done = 1'b1;
            state_next     = S_IDLE;
          end else begin
            cmd.round_inc = 1'b1;
            state_next    = S_F_ADDR;
          end
        end
      end
      S_R_ADDR: begin
        if (sts.out_free) begin
          cmd.load   = 1'b1;
          cmd.sel    = SEL_REP_ADDR;
          state_next = S_R_DATA;
        end
      end
      S_R_DATA: begin
        if (sts.out_free) begin
          cmd.load = 1'b1;
          cmd.sel  = SEL_REP_DATA;
          if (sts.rep_last) begin
            cmd.last   = 1'b1;
            state_next = S_IDLE;
          end else begin
            cmd.rep_step = 1'b1;
            state_next   = S_R_ADDR;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      rej   <= 1'b0;
    end else begin
      state <= state_next;
      rej   <= rej_next;
    end
  end

endmodule

// ===== rtl/psgfrd_dp.sv =====
// Datapath: chip FIFOs, shadow store, bit remap, frame counter, config and output register.
// Depends on psgfrd_pkg and psgfrd_ram.
`timescale 1ns / 1ps
module psgfrd_dp
  import psgfrd_pkg::*;
#(
  parameter int NUM_CHIPS  = 2,
  parameter int FIFO_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  in_item_t    in_data,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [23:0] cfg_data,
  input  cmd_t        cmd,
  output status_t     sts,
  output logic        out_valid,
  input  logic        out_ready,
  output out_item_t   out_data
);

  localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

  logic [23:0]         bit_map [NUM_CHIPS];
  logic [7:0]          fps;
  logic                pulse_en;
  logic [PTR_W-1:0]    head [NUM_CHIPS];
  logic [PTR_W-1:0]    tail [NUM_CHIPS];
  logic [CNT_W-1:0]    count [NUM_CHIPS];
  logic [15:0]         item [NUM_CHIPS];
  logic                ended [NUM_CHIPS];
  logic [7:0]          last_val [NUM_CHIPS];
  logic [7:0]          shadow [NUM_CHIPS][16];
  logic [7:0]          lane_fa [NUM_CHIPS];
  logic [7:0]          lane_fd [NUM_CHIPS];
  logic [7:0]          lane_ra [NUM_CHIPS];
  logic [7:0]          lane_rd [NUM_CHIPS];
  logic [MAX_CHIPS-1:0] full_vec;
  logic [31:0]         bus_fa, bus_fd, bus_ra, bus_rd;
  logic [ROUND_W-1:0]  round;
  logic [SHADOW_W-1:0] rep_idx;
  logic [7:0]          frame_counter, fc_inc;
  logic                pulse_hit;
  logic                all_ended, any_nonempty;
  out_item_t           out_next;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      fps      <= FPS_RESET;
      pulse_en <= 1'b1;
    end else if (cfg_we) begin
      if (cfg_index == CFG_FPS) fps <= cfg_data[7:0];
      if (cfg_index == CFG_PULSE_EN) pulse_en <= cfg_data[0];
    end
  end

  for (genvar g = 0; g < NUM_CHIPS; g++) begin : g_chip
    logic [7:0] pop_reg;
    logic       has;
    logic [7:0] addr_reg;
    logic       do_pop;

    always_ff @(posedge clk) begin
      if (rst) bit_map[g] <= MAP_RESET;
      else if (cfg_we && cfg_index == CFG_MAP0 + 3'(g)) bit_map[g] <= cfg_data;
    end

    psgfrd_ram #(.WIDTH(16), .DEPTH(SLOTS)) u_fifo_ram (
      .clk   (clk),
      .we    (cmd.push && in_data.chip_select == 2'(g)),
      .waddr (tail[g]),
      .wdata ({in_data.reg_number, in_data.reg_value}),
      .raddr (head[g]),
      .rdata (item[g])
    );

    assign pop_reg  = item[g][15:8];
    assign has      = (count[g] != '0);
    assign do_pop   = cmd.pop && !ended[g];
    assign addr_reg = (!ended[g] && has && pop_reg != END_MARK) ? pop_reg : IDLE_REG;

    always_ff @(posedge clk) begin
      if (rst) begin
        head[g]     <= '0;
        tail[g]     <= '0;
        count[g]    <= '0;
        ended[g]    <= 1'b0;
        last_val[g] <= '0;
      end else begin
        if (cmd.flush) begin
          head[g]  <= '0;
          tail[g]  <= '0;
          count[g] <= '0;
        end else if (cmd.push && in_data.chip_select == 2'(g)) begin
          tail[g]  <= tail[g] + 1'b1;
          count[g] <= count[g] + 1'b1;
        end else if (do_pop && has) begin
          head[g]  <= head[g] + 1'b1;
          count[g] <= count[g] - 1'b1;
        end
        if (cmd.start_frame) ended[g] <= 1'b0;
        else if (do_pop && (!has || pop_reg == END_MARK)) ended[g] <= 1'b1;
        if (do_pop && has) last_val[g] <= item[g][7:0];
      end
    end

    // Shadow copy of registers 0..15.
    always_ff @(posedge clk) begin
      if (rst) begin
        for (int r = 0; r < 16; r++) shadow[g][r] <= '0;
      end else if (cmd.clear_shadow) begin
        for (int r = 0; r < 16; r++) shadow[g][r] <= (4'(r) == MIXER_REG) ? MIXER_OFF : 8'd0;
      end else if (do_pop && has && pop_reg < SHADOW_N) begin
        shadow[g][pop_reg[3:0]] <= item[g][7:0];
      end
    end

    assign lane_fa[g] = remap(bit_map[g], addr_reg);
    assign lane_fd[g] = remap(bit_map[g], last_val[g]);
    assign lane_ra[g] = remap(bit_map[g], {4'd0, rep_idx});
    assign lane_rd[g] = remap(bit_map[g], shadow[g][rep_idx]);
  end

  for (genvar c = 0; c < MAX_CHIPS; c++) begin : g_lane
    if (c < NUM_CHIPS) begin : g_used
      assign bus_fa[8*c +: 8] = lane_fa[c];
      assign bus_fd[8*c +: 8] = lane_fd[c];
      assign bus_ra[8*c +: 8] = lane_ra[c];
      assign bus_rd[8*c +: 8] = lane_rd[c];
      assign full_vec[c]      = (count[c] >= CNT_W'(FIFO_DEPTH));
    end else begin : g_unused
      assign bus_fa[8*c +: 8] = '0;
      assign bus_fd[8*c +: 8] = '0;
      assign bus_ra[8*c +: 8] = '0;
      assign bus_rd[8*c +: 8] = '0;
      assign full_vec[c]      = 1'b1;
    end
  end

  always_comb begin
    all_ended    = 1'b1;
    any_nonempty = 1'b0;
    for (int c = 0; c < NUM_CHIPS; c++) begin
      if (!ended[c]) all_ended = 1'b0;
      if (count[c] != '0) any_nonempty = 1'b1;
    end
  end

  // Round and replay counters.
  always_ff @(posedge clk) begin
    if (rst) begin
      round   <= '0;
      rep_idx <= '0;
    end else begin
      if (cmd.start_frame) round <= '0;
      else if (cmd.round_inc) round <= round + 1'b1;
      if (cmd.rep_start) rep_idx <= '0;
      else if (cmd.rep_step) rep_idx <= rep_idx + 1'b1;
    end
  end

  // Frame counter and second pulse.
  assign fc_inc    = frame_counter + 8'd1;
  assign pulse_hit = (fc_inc == fps);

  always_ff @(posedge clk) begin
    if (rst) frame_counter <= '0;
    else if (cmd.frame_done) frame_counter <= pulse_hit ? 8'd0 : fc_inc;
  end

  always_comb begin
    out_next              = '0;
    out_next.last         = cmd.last;
    out_next.second_pulse = cmd.frame_done && pulse_hit && pulse_en;
    unique case (cmd.sel)
      SEL_ACK:        out_next.kind = KIND_ACK;
      SEL_REJ:        out_next.kind = KIND_REJ;
      SEL_FRAME_ADDR: begin
        out_next.kind      = KIND_ADDR;
        out_next.bus_bytes = bus_fa;
      end
      SEL_FRAME_DATA: begin
        out_next.kind      = KIND_DATA;
        out_next.bus_bytes = bus_fd;
      end
      SEL_REP_ADDR: begin
        out_next.kind      = KIND_ADDR;
        out_next.bus_bytes = bus_ra;
      end
      SEL_REP_DATA: begin
        out_next.kind      = KIND_DATA;
        out_next.bus_bytes = bus_rd;
      end
      default: out_next.kind = KIND_ACK;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (cmd.load) out_valid <= 1'b1;
    else if (out_ready) out_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) out_data <= out_next;
  end

  assign sts.enq_ok       = !full_vec[in_data.chip_select];
  assign sts.any_nonempty = any_nonempty;
  assign sts.frame_end    = all_ended || (&round);
  assign sts.rep_last     = &rep_idx;
  assign sts.out_free     = !out_valid || out_ready;

endmodule

// ===== rtl/psg_frame_register_dispatcher_unit.sv =====
// Frame register dispatcher, top level: controller plus datapath.
// Depends on psgfrd_pkg, psgfrd_ctrl, psgfrd_dp (and psgfrd_ram below it).
// An enqueue reply goes through state S_ENQ into the output register; a frame
// or replay puts out one bus transaction per cycle (2 per round, 32 for a
// replay) when the output is not stalled.
// Reset (synchronous, rst high) empties the FIFOs and clears shadow and counters.
`timescale 1ns / 1ps
module psg_frame_register_dispatcher_unit
  import psgfrd_pkg::*;
#(
  parameter int NUM_CHIPS  = 2,
  parameter int FIFO_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  // input transaction
  input  logic        in_valid,
  output logic        in_ready,
  input  in_item_t    in_data,
  // result transaction
  output logic        out_valid,
  input  logic        out_ready,
  output out_item_t   out_data,
  // configuration writes
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [23:0] cfg_data
);

  cmd_t    cmd;
  status_t sts;

  // Sequence each accepted transaction; the output register lets the next
  // transaction be taken while the final result still waits downstream.
  psgfrd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .opcode   (in_data.opcode),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Hold FIFOs, shadow store, remap and output register.
  psgfrd_dp #(
    .NUM_CHIPS  (NUM_CHIPS),
    .FIFO_DEPTH (FIFO_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ===== tb/tb_psg_frame_register_dispatcher_unit.sv =====
// Self-checking testbench of the frame register dispatcher: it drives input transactions,
// predicts the bus and reply transactions in its own model and compares them.
// Depends on psgfrd_pkg and psg_frame_register_dispatcher_unit.
`timescale 1ns / 1ps
module tb_psg_frame_register_dispatcher_unit;
  import psgfrd_pkg::*;

  localparam int CHIPS      = 2;
  localparam int DEPTH      = 16;
  localparam int HOLD_OFF   = 300;   // receiver hold-off in cycles
  localparam int DRAIN_WAIT = 100;   // latency allowance before config and at the end
  localparam int STALL_MAX  = 4000;  // cycles with no transaction before giving up

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  in_item_t    in_data;
  logic        out_valid;
  logic        out_ready;
  out_item_t   out_data;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [23:0] cfg_data;

  psg_frame_register_dispatcher_unit #(
    .NUM_CHIPS (CHIPS),
    .FIFO_DEPTH(DEPTH)
  ) u_top (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // 4 ns period
  always begin
    clk = 1'b1; #2;
    clk = 1'b0; #2;
  end

  // Dispatcher state as the testbench sees it
  logic [23:0] pin_map [MAX_CHIPS];
  logic [7:0]  fps_limit;
  logic        pulse_en;
  logic [15:0] pair_store [MAX_CHIPS][SLOTS];
  int          rd_ptr [MAX_CHIPS];
  int          wr_ptr [MAX_CHIPS];
  int          fill [MAX_CHIPS];
  logic [7:0]  shadow [MAX_CHIPS][16];
  logic [7:0]  held_value [MAX_CHIPS];
  logic [7:0]  frame_count;

  out_item_t bus_expected[$];
  int        fail_count;
  int        items_sent;
  bit        no_idle;     // long stretch with both sides busy
  bit        hold_req;    // ask the receiver for a long hold-off

  // Route source bit i to the position named by field i of the map.
  function automatic logic [7:0] pin_route(logic [23:0] m, logic [7:0] b);
    logic [7:0] r;
    logic [2:0] dst;
    r = 8'h00;
    for (int i = 0; i < 8; i++) begin
      dst = m[3*i +: 3];
      r = r | ({7'd0, b[i]} << dst);
    end
    return r;
  endfunction

  function automatic void add_expected(logic [1:0] k, logic [31:0] bus, logic p, logic l);
    out_item_t e;
    e.kind         = k;
    e.bus_bytes    = bus;
    e.second_pulse = p;
    e.last         = l;
    bus_expected.push_back(e);
  endfunction

  function automatic void predict_replay();
    logic [31:0] a, d;
    for (int r = 0; r < 16; r++) begin
      a = '0;
      d = '0;
      for (int c = 0; c < CHIPS; c++) begin
        a[8*c +: 8] = pin_route(pin_map[c], 8'(r));
        d[8*c +: 8] = pin_route(pin_map[c], shadow[c][r]);
      end
      add_expected(KIND_ADDR, a, 1'b0, 1'b0);
      add_expected(KIND_DATA, d, 1'b0, r == 15);
    end
  endfunction

  // Pop rounds until every chip has hit its end mark or run dry, or the round limit is reached.
  function automatic void predict_frame();
    bit          done [MAX_CHIPS];
    bit          any, active;
    int          n;
    logic [7:0]  rg;
    logic [15:0] pr;
    logic [31:0] a, d;
    any = 0;
    n = 0;
    for (int c = 0; c < CHIPS; c++) begin
      done[c] = 0;
      if (fill[c] != 0) any = 1;
    end
    if (!any) return;
    forever begin
      active = 0;
      for (int c = 0; c < CHIPS; c++) if (!done[c]) active = 1;
      if (!active || n + 2 > 64) break;
      a = '0;
      d = '0;
      for (int c = 0; c < CHIPS; c++) begin
        rg = IDLE_REG;
        if (!done[c]) begin
          if (fill[c] != 0) begin
            pr = pair_store[c][rd_ptr[c]];
            rd_ptr[c] = (rd_ptr[c] + 1) % SLOTS;
            fill[c]--;
            rg = pr[15:8];
            held_value[c] = pr[7:0];
            if (rg == END_MARK) begin
              rg = IDLE_REG;
              done[c] = 1;
            end else if (rg < SHADOW_N) begin
              shadow[c][rg[3:0]] = held_value[c];
            end
          end else begin
            done[c] = 1;
          end
        end
        a[8*c +: 8] = pin_route(pin_map[c], rg);
        d[8*c +: 8] = pin_route(pin_map[c], held_value[c]);
      end
      add_expected(KIND_ADDR, a, 1'b0, 1'b0);
      add_expected(KIND_DATA, d, 1'b0, 1'b0);
      n += 2;
    end
    frame_count = frame_count + 8'd1;
    if (frame_count == fps_limit) begin
      frame_count = 8'd0;
      bus_expected[bus_expected.size()-1].second_pulse = pulse_en;
    end
    bus_expected[bus_expected.size()-1].last = 1'b1;
  endfunction

  function automatic void predict_item(in_item_t it);
    case (it.opcode)
      OP_ENQUEUE: begin
        if (it.chip_select >= CHIPS || fill[it.chip_select] >= DEPTH) begin
          add_expected(KIND_REJ, '0, 1'b0, 1'b1);
        end else begin
          pair_store[it.chip_select][wr_ptr[it.chip_select]] = {it.reg_number, it.reg_value};
          wr_ptr[it.chip_select] = (wr_ptr[it.chip_select] + 1) % SLOTS;
          fill[it.chip_select]++;
          add_expected(KIND_ACK, '0, 1'b0, 1'b1);
        end
      end
      OP_TICK:   predict_frame();
      OP_RESEND: predict_replay();
      OP_CLEAR: begin
        for (int c = 0; c < CHIPS; c++)
          for (int r = 0; r < 16; r++)
            shadow[c][r] = (r == MIXER_REG) ? MIXER_OFF : 8'h00;
        predict_replay();
      end
      OP_FLUSH: begin
        for (int c = 0; c < CHIPS; c++) begin
          rd_ptr[c] = 0;
          wr_ptr[c] = 0;
          fill[c]   = 0;
        end
      end
      default: ;  // unknown opcodes are dropped
    endcase
  endfunction

  // Offer one transaction at the falling edge, hold it until accepted, then predict.
  task automatic send_item(logic [2:0] op, logic [1:0] chip, logic [7:0] rg, logic [7:0] val);
    in_item_t it;
    it.opcode      = op;
    it.chip_select = chip;
    it.reg_number  = rg;
    it.reg_value   = val;
    @(negedge clk);
    while (!no_idle && $urandom_range(99) < 19) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
    predict_item(it);
    items_sent++;
  endtask

  // Drop valid, drain every expected transaction, then allow for trailing work.
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    wait (bus_expected.size() == 0);
    repeat (DRAIN_WAIT) @(negedge clk);
  endtask

  // Write one register while the block is idle.
  task automatic cfg_write(logic [2:0] idx, logic [23:0] val);
    drain();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we    <= 1'b0;
    if (idx < CFG_FPS)           pin_map[idx] = val;
    else if (idx == CFG_FPS)     fps_limit    = val[7:0];
    else if (idx == CFG_PULSE_EN) pulse_en    = val[0];
  endtask

  task automatic set_maps(logic [23:0] m0, logic [23:0] m1, logic [23:0] m2, logic [23:0] m3);
    cfg_write(CFG_MAP0 + 3'd0, m0);
    cfg_write(CFG_MAP0 + 3'd1, m1);
    cfg_write(CFG_MAP0 + 3'd2, m2);
    cfg_write(CFG_MAP0 + 3'd3, m3);
  endtask

  // Field extremes, every opcode and the corner cases of the frame logic.
  task automatic test_directed();
    send_item(OP_TICK, 2'd0, 8'd0, 8'd0);            // empty frame: nothing out
    send_item(OP_ENQUEUE, 2'd0, 8'd0, 8'd0);
    send_item(OP_ENQUEUE, 2'd1, 8'd15, 8'hFF);
    send_item(OP_ENQUEUE, 2'd0, 8'd16, 8'hA5);       // not shadowed
    send_item(OP_ENQUEUE, 2'd1, 8'd254, 8'h5A);
    send_item(OP_ENQUEUE, 2'd0, END_MARK, 8'h81);
    send_item(OP_ENQUEUE, 2'd2, 8'd3, 8'h11);        // chip out of range
    send_item(OP_ENQUEUE, 2'd3, 8'hFF, 8'hFF);
    send_item(OP_TICK, 2'd3, 8'hFF, 8'hFF);          // chip 1 runs dry
    send_item(OP_RESEND, 2'd0, 8'd0, 8'd0);
    send_item(OP_CLEAR, 2'd0, 8'd0, 8'd0);
    send_item(OP_ENQUEUE, 2'd1, 8'd7, 8'h01);
    send_item(OP_FLUSH, 2'd0, 8'd0, 8'd0);
    send_item(OP_TICK, 2'd0, 8'd0, 8'd0);            // flushed: nothing out
    send_item(3'd5, 2'd1, 8'h55, 8'hAA);
    send_item(3'd6, 2'd2, 8'hAA, 8'h55);
    send_item(3'd7, 2'd3, 8'hFF, 8'hFF);
  endtask

  // Fill chip 0 past its depth, then pop the full FIFO with no end mark.
  task automatic test_fifo_full();
    for (int i = 0; i <= DEPTH; i++)
      send_item(OP_ENQUEUE, 2'd0, 8'($urandom_range(15)), 8'($urandom));
    send_item(OP_TICK, 2'd0, 8'd0, 8'd0);
  endtask

  // Pulse cadence: every frame, then disabled, then the 8-bit wrap setting.
  task automatic test_second_pulse();
    cfg_write(CFG_FPS, 24'd1);
    for (int i = 0; i < 3; i++) begin
      send_item(OP_ENQUEUE, 2'(i % 2), 8'($urandom_range(15)), 8'($urandom));
      send_item(OP_TICK, 2'd0, 8'd0, 8'd0);
    end
    cfg_write(CFG_PULSE_EN, 24'd0);
    send_item(OP_ENQUEUE, 2'd1, END_MARK, 8'h00);
    send_item(OP_TICK, 2'd0, 8'd0, 8'd0);
    cfg_write(CFG_PULSE_EN, 24'd1);
    cfg_write(CFG_FPS, 24'd0);
    send_item(OP_ENQUEUE, 2'd0, 8'd2, 8'h33);
    send_item(OP_TICK, 2'd0, 8'd0, 8'd0);
    cfg_write(CFG_FPS, 24'd255);
    cfg_write(CFG_FPS, 24'd2);
  endtask

  // Hold the receiver off while enqueues keep coming, so the input stalls.
  task automatic test_backpressure();
    drain();
    hold_req = 1'b1;
    for (int i = 0; i < 24; i++)
      send_item(OP_ENQUEUE, 2'($urandom_range(3)), 8'($urandom), 8'($urandom));
    send_item(OP_TICK, 2'd0, 8'd0, 8'd0);
    send_item(OP_FLUSH, 2'd0, 8'd0, 8'd0);
  endtask

  // Mostly well-formed frames with random content, plus replays and noise.
  task automatic test_random(int target, bit busy);
    int n, sel;
    no_idle = busy;
    while (items_sent < target) begin
      sel = $urandom_range(99);
      if (sel < 70) begin
        for (int c = 0; c < CHIPS; c++) begin
          n = $urandom_range(5);
          for (int i = 0; i < n; i++)
            send_item(OP_ENQUEUE, 2'(c),
                      ($urandom_range(99) < 65) ? 8'($urandom_range(15)) : 8'($urandom),
                      8'($urandom));
          if ($urandom_range(99) < 70) send_item(OP_ENQUEUE, 2'(c), END_MARK, 8'($urandom));
        end
        if ($urandom_range(99) < 10)
          send_item(OP_ENQUEUE, 2'($urandom_range(2, 3)), 8'($urandom), 8'($urandom));
        send_item(OP_TICK, 2'($urandom), 8'($urandom), 8'($urandom));
      end else if (sel < 80) begin
        send_item(OP_RESEND, 2'($urandom), 8'($urandom), 8'($urandom));
      end else if (sel < 85) begin
        send_item(OP_CLEAR, 2'($urandom), 8'($urandom), 8'($urandom));
      end else if (sel < 90) begin
        send_item(OP_FLUSH, 2'($urandom), 8'($urandom), 8'($urandom));
      end else if (sel < 94) begin
        send_item(3'($urandom_range(5, 7)), 2'($urandom), 8'($urandom), 8'($urandom));
      end else begin
        send_item(3'($urandom), 2'($urandom), 8'($urandom), 8'($urandom));
      end
    end
    no_idle = 1'b0;
  endtask

  // Receiver: random stalls, a quiet stretch, and the long hold-off on request.
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_OFF) @(negedge clk);
        hold_req = 1'b0;
      end
      out_ready <= no_idle || ($urandom_range(99) >= 19);
    end
  end

  // Compare each result transaction with the oldest expectation.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (bus_expected.size() == 0) begin
        $error("unexpected result transaction kind=%0d bus=%h", out_data.kind, out_data.bus_bytes);
        fail_count++;
      end else begin
        out_item_t e;
        e = bus_expected.pop_front();
        if (out_data.kind !== e.kind) begin
          $error("kind: expected %0d actual %0d", e.kind, out_data.kind);
          fail_count++;
        end
        if (out_data.bus_bytes !== e.bus_bytes) begin
          $error("bus_bytes: expected %h actual %h", e.bus_bytes, out_data.bus_bytes);
          fail_count++;
        end
        if (out_data.second_pulse !== e.second_pulse) begin
          $error("second_pulse: expected %0d actual %0d", e.second_pulse,
                 out_data.second_pulse);
          fail_count++;
        end
        if (out_data.last !== e.last) begin
          $error("last: expected %0d actual %0d", e.last, out_data.last);
          fail_count++;
        end
      end
    end
  end

  // Watchdog: count cycles in which neither channel moves a transaction.
  int idle_cycles;
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_MAX) begin
        $display("tb_psg_frame_register_dispatcher_unit failed");
        $finish;
      end
    end
  end

  initial begin
    rst        = 1'b1;
    in_valid   = 1'b0;
    in_data    = '0;
    cfg_we     = 1'b0;
    cfg_index  = '0;
    cfg_data   = '0;
    fail_count = 0;
    items_sent = 0;
    no_idle    = 1'b0;
    hold_req   = 1'b0;
    for (int c = 0; c < MAX_CHIPS; c++) begin
      pin_map[c]    = MAP_RESET;
      rd_ptr[c]     = 0;
      wr_ptr[c]     = 0;
      fill[c]       = 0;
      held_value[c] = 8'h00;
      for (int r = 0; r < 16; r++) shadow[c][r] = 8'h00;
    end
    fps_limit   = FPS_RESET;
    pulse_en    = 1'b1;
    frame_count = 8'h00;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_directed();
    test_fifo_full();
    test_second_pulse();
    set_maps(24'h000000, 24'hFFFFFF, 24'h000000, 24'hFFFFFF);
    test_directed();
    set_maps(24'h053977, 24'($urandom), 24'($urandom), 24'($urandom));
    test_backpressure();
    test_random(items_sent + 70, 1'b1);
    set_maps(24'($urandom), 24'($urandom), 24'hFFFFFF, 24'h000000);
    cfg_write(CFG_FPS, 24'd3);
    test_random(items_sent + 35, 1'b0);
    set_maps(MAP_RESET, MAP_RESET, MAP_RESET, MAP_RESET);
    cfg_write(CFG_FPS, 24'd7);
    test_random(items_sent + 30, 1'b0);

    drain();
    if (fail_count == 0) begin
      $display("tb_psg_frame_register_dispatcher_unit passed");
    end else begin
      $display("tb_psg_frame_register_dispatcher_unit failed");
    end
    $finish;
  end

endmodule
